FILE: rtl/fslxa_pkg.sv
// ----------------------------------------------------------------------------
// fslxa_pkg
// Shared types, codes and helpers for the framed serial link engine.
// ----------------------------------------------------------------------------
package fslxa_pkg;

  // Default payload length width
  localparam int LENGTH_BITS_DEF = 16;

  // Most results one transaction can cause
  localparam int BURST_MAX = 4;
  localparam int BURST_CW  = $clog2(BURST_MAX + 1);

  // Register reset values
  localparam logic [7:0]  ACK_CODE_RST      = 8'h06;
  localparam logic [7:0]  NAK_CODE_RST      = 8'h15;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'd1024;
  localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd10;

  // Register indexes (word address)
  localparam logic [1:0] REG_ACK_CODE      = 2'd0;
  localparam logic [1:0] REG_NAK_CODE      = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd3;

  // Input transaction modes
  localparam logic [2:0] MODE_LINE_BYTE  = 3'd0;
  localparam logic [2:0] MODE_TICK       = 3'd1;
  localparam logic [2:0] MODE_START_SEND = 3'd2;
  localparam logic [2:0] MODE_SEND_BYTE  = 3'd3;
  localparam logic [2:0] MODE_START_RECV = 3'd4;
  localparam logic [2:0] MODE_AWAIT_ACK  = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT = 3'd1;
  localparam logic [2:0] ERR_SEND    = 3'd2;
  localparam logic [2:0] ERR_RECV    = 3'd3;
  localparam logic [2:0] ERR_GENERAL = 3'd4;

  localparam logic [7:0] ECHO_MAX = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SEND_DATA  = 3'd1,
    PH_SEND_REPLY = 3'd2,
    PH_RECV_HI    = 3'd3,
    PH_RECV_LO    = 3'd4,
    PH_RECV_DATA  = 3'd5,
    PH_RECV_CHK   = 3'd6,
    PH_ACK_WAIT   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0]  ack_code;
    logic [7:0]  nak_code;
    logic [15:0] max_length;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  line_byte;
    logic [3:0]  device;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        done_res;
    logic        success;
    logic [2:0]  error_code;
    logic [15:0] rx_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [BURST_CW-1:0]        count;
    res_t [BURST_MAX-1:0]       slot;
  } burst_t;

  // Line byte to transmit
  function automatic res_t tx_res(input logic [7:0] b);
    res_t r;
    r          = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    return r;
  endfunction

  // Received payload byte
  function automatic res_t rx_res(input logic [7:0] b);
    res_t r;
    r          = '0;
    r.rx_valid = 1'b1;
    r.rx_data  = b;
    return r;
  endfunction

  // Operation finished
  function automatic res_t fin_res(input logic ok, input logic [2:0] err,
                                   input logic [15:0] len);
    res_t r;
    r            = '0;
    r.done_res   = 1'b1;
    r.success    = ok;
    r.error_code = err;
    r.rx_length  = len;
    return r;
  endfunction

endpackage

FILE: rtl/fslxa_cfg.sv
// ----------------------------------------------------------------------------
// fslxa_cfg
// APB-style register file: ACK/NAK codes, length clamp and timeout limit.
// ----------------------------------------------------------------------------
module fslxa_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output fslxa_pkg::cfg_t      cfg
);

  fslxa_pkg::cfg_t cfg_r;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_code      <= fslxa_pkg::ACK_CODE_RST;
      cfg_r.nak_code      <= fslxa_pkg::NAK_CODE_RST;
      cfg_r.max_length    <= fslxa_pkg::MAX_LENGTH_RST;
      cfg_r.timeout_limit <= fslxa_pkg::TIMEOUT_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        fslxa_pkg::REG_ACK_CODE:      cfg_r.ack_code      <= pwdata[7:0];
        fslxa_pkg::REG_NAK_CODE:      cfg_r.nak_code      <= pwdata[7:0];
        fslxa_pkg::REG_MAX_LENGTH:    cfg_r.max_length    <= pwdata[15:0];
        fslxa_pkg::REG_TIMEOUT_LIMIT: cfg_r.timeout_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      fslxa_pkg::REG_ACK_CODE:      prdata = {24'd0, cfg_r.ack_code};
      fslxa_pkg::REG_NAK_CODE:      prdata = {24'd0, cfg_r.nak_code};
      fslxa_pkg::REG_MAX_LENGTH:    prdata = {16'd0, cfg_r.max_length};
      fslxa_pkg::REG_TIMEOUT_LIMIT: prdata = {16'd0, cfg_r.timeout_limit};
      default:                      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/fslxa_engine.sv
// ----------------------------------------------------------------------------
// fslxa_engine
// Link state and single-pass step logic: one transaction in, a burst of up
// to four results out, state updated at the same edge.
// ----------------------------------------------------------------------------
module fslxa_engine #(
  parameter int LENGTH_BITS = fslxa_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  fslxa_pkg::item_t     item,
  input  fslxa_pkg::cfg_t      cfg,
  output fslxa_pkg::burst_t    burst
);

  localparam int LB = LENGTH_BITS;

  fslxa_pkg::phase_t phase_r, phase_nxt;
  logic [LB-1:0]     byte_count_r, byte_count_nxt;
  logic [LB-1:0]     exp_len_r, exp_len_nxt;
  logic [7:0]        run_xor_r, run_xor_nxt;
  logic [15:0]       wait_ticks_r, wait_ticks_nxt;
  logic [7:0]        echoes_r, echoes_nxt;

  logic [15:0]       wt_inc;
  logic [LB:0]       cnt_inc;
  logic [LB-1:0]     len_raw;
  logic [15:0]       len_ext;
  logic [7:0]        xor_b;
  logic [2:0]        echo_add;
  logic              echo_dec;
  logic [8:0]        echo_sum;
  logic              waiting;

  // Step logic
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    exp_len_nxt    = exp_len_r;
    run_xor_nxt    = run_xor_r;
    wait_ticks_nxt = wait_ticks_r;
    burst          = '0;
    echo_add       = '0;
    echo_dec       = 1'b0;
    len_raw        = '0;
    len_ext        = '0;

    wt_inc  = (wait_ticks_r == 16'hFFFF) ? wait_ticks_r : wait_ticks_r + 16'd1;
    cnt_inc = {1'b0, byte_count_r} + {{LB{1'b0}}, 1'b1};
    waiting = (phase_r != fslxa_pkg::PH_IDLE) && (phase_r != fslxa_pkg::PH_SEND_DATA);
    xor_b   = (item.mode == fslxa_pkg::MODE_SEND_BYTE) ?
              (run_xor_r ^ item.payload_byte) : (run_xor_r ^ item.line_byte);

    if (accept) begin
      case (item.mode)
        fslxa_pkg::MODE_LINE_BYTE: begin
          if (echoes_r != 8'd0) begin
            // echo of our own transmission
            echo_dec = 1'b1;
          end else begin
            case (phase_r)
              fslxa_pkg::PH_SEND_REPLY: begin
                phase_nxt          = fslxa_pkg::PH_IDLE;
                burst.count        = fslxa_pkg::BURST_CW'(1);
                burst.slot[0]      = (item.line_byte == cfg.ack_code) ?
                  fslxa_pkg::fin_res(1'b1, fslxa_pkg::ERR_NONE, 16'd0) :
                  fslxa_pkg::fin_res(1'b0, fslxa_pkg::ERR_SEND, 16'd0);
              end
              fslxa_pkg::PH_ACK_WAIT: begin
                phase_nxt          = fslxa_pkg::PH_IDLE;
                burst.count        = fslxa_pkg::BURST_CW'(1);
                burst.slot[0]      = (item.line_byte == cfg.ack_code) ?
                  fslxa_pkg::fin_res(1'b1, fslxa_pkg::ERR_NONE, 16'd0) :
                  fslxa_pkg::fin_res(1'b0, fslxa_pkg::ERR_GENERAL, 16'd0);
              end
              fslxa_pkg::PH_RECV_HI: begin
                exp_len_nxt    = LB'({item.line_byte, 8'h00});
                phase_nxt      = fslxa_pkg::PH_RECV_LO;
                wait_ticks_nxt = '0;
              end
              fslxa_pkg::PH_RECV_LO: begin
                len_raw        = exp_len_r | LB'(item.line_byte);
                len_ext        = 16'(len_raw);
                // clamp to max_length
                exp_len_nxt    = (len_ext > cfg.max_length) ?
                                 cfg.max_length[LB-1:0] : len_raw;
                byte_count_nxt = '0;
                run_xor_nxt    = '0;
                phase_nxt      = (exp_len_nxt == '0) ? fslxa_pkg::PH_RECV_CHK :
                                                       fslxa_pkg::PH_RECV_DATA;
                wait_ticks_nxt = '0;
              end
              fslxa_pkg::PH_RECV_DATA: begin
                run_xor_nxt    = xor_b;
                byte_count_nxt = cnt_inc[LB-1:0];
                if (cnt_inc >= {1'b0, exp_len_r}) begin
                  phase_nxt = fslxa_pkg::PH_RECV_CHK;
                end
                wait_ticks_nxt = '0;
                burst.count    = fslxa_pkg::BURST_CW'(1);
                burst.slot[0]  = fslxa_pkg::rx_res(item.line_byte);
              end
              fslxa_pkg::PH_RECV_CHK: begin
                // answer ACK or NAK, which is itself echoed
                echo_add    = 3'd1;
                phase_nxt   = fslxa_pkg::PH_IDLE;
                burst.count = fslxa_pkg::BURST_CW'(1);
                if (item.line_byte == run_xor_r) begin
                  burst.slot[0] = fslxa_pkg::fin_res(1'b1, fslxa_pkg::ERR_NONE,
                                                     16'(exp_len_r));
                  burst.slot[0].tx_valid = 1'b1;
                  burst.slot[0].tx_byte  = cfg.ack_code;
                end else begin
                  burst.slot[0] = fslxa_pkg::fin_res(1'b0, fslxa_pkg::ERR_RECV, 16'd0);
                  burst.slot[0].tx_valid = 1'b1;
                  burst.slot[0].tx_byte  = cfg.nak_code;
                end
              end
              default: ;
            endcase
          end
        end
        fslxa_pkg::MODE_TICK: begin
          if (waiting) begin
            wait_ticks_nxt = wt_inc;
            if (wt_inc > cfg.timeout_limit) begin
              phase_nxt     = fslxa_pkg::PH_IDLE;
              burst.count   = fslxa_pkg::BURST_CW'(1);
              burst.slot[0] = fslxa_pkg::fin_res(1'b0, fslxa_pkg::ERR_TIMEOUT, 16'd0);
            end
          end
        end
        fslxa_pkg::MODE_START_SEND: begin
          len_raw        = item.frame_length[LB-1:0];
          len_ext        = 16'(len_raw);
          exp_len_nxt    = len_raw;
          byte_count_nxt = '0;
          run_xor_nxt    = '0;
          wait_ticks_nxt = '0;
          // header: device, length high, length low
          burst.slot[0]  = fslxa_pkg::tx_res({4'd0, item.device});
          burst.slot[1]  = fslxa_pkg::tx_res(len_ext[15:8]);
          burst.slot[2]  = fslxa_pkg::tx_res(len_ext[7:0]);
          if (len_raw == '0) begin
            // empty frame: checksum follows at once
            burst.slot[3] = fslxa_pkg::tx_res(8'd0);
            burst.count   = fslxa_pkg::BURST_CW'(4);
            echo_add      = 3'd4;
            phase_nxt     = fslxa_pkg::PH_SEND_REPLY;
          end else begin
            burst.count   = fslxa_pkg::BURST_CW'(3);
            echo_add      = 3'd3;
            phase_nxt     = fslxa_pkg::PH_SEND_DATA;
          end
        end
        fslxa_pkg::MODE_SEND_BYTE: begin
          if (phase_r == fslxa_pkg::PH_SEND_DATA) begin
            run_xor_nxt    = xor_b;
            byte_count_nxt = cnt_inc[LB-1:0];
            burst.slot[0]  = fslxa_pkg::tx_res(item.payload_byte);
            if (cnt_inc >= {1'b0, exp_len_r}) begin
              burst.slot[1]  = fslxa_pkg::tx_res(xor_b);
              burst.count    = fslxa_pkg::BURST_CW'(2);
              echo_add       = 3'd2;
              phase_nxt      = fslxa_pkg::PH_SEND_REPLY;
              wait_ticks_nxt = '0;
            end else begin
              burst.count    = fslxa_pkg::BURST_CW'(1);
              echo_add       = 3'd1;
            end
          end
        end
        fslxa_pkg::MODE_START_RECV: begin
          byte_count_nxt = '0;
          exp_len_nxt    = '0;
          run_xor_nxt    = '0;
          wait_ticks_nxt = '0;
          phase_nxt      = fslxa_pkg::PH_RECV_HI;
        end
        fslxa_pkg::MODE_AWAIT_ACK: begin
          wait_ticks_nxt = '0;
          phase_nxt      = fslxa_pkg::PH_ACK_WAIT;
        end
        default: ;
      endcase
    end

    // mark the final result of the burst
    if (burst.count != '0) begin
      burst.slot[2'(burst.count - fslxa_pkg::BURST_CW'(1))].last = 1'b1;
    end

    // echo count, saturating
    echo_sum = {1'b0, echoes_r} + 9'(echo_add);
    if (echo_dec) begin
      echoes_nxt = echoes_r - 8'd1;
    end else if (echo_sum > {1'b0, fslxa_pkg::ECHO_MAX}) begin
      echoes_nxt = fslxa_pkg::ECHO_MAX;
    end else begin
      echoes_nxt = echo_sum[7:0];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fslxa_pkg::PH_IDLE;
      byte_count_r <= '0;
      exp_len_r    <= '0;
      run_xor_r    <= '0;
      wait_ticks_r <= '0;
      echoes_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      exp_len_r    <= exp_len_nxt;
      run_xor_r    <= run_xor_nxt;
      wait_ticks_r <= wait_ticks_nxt;
      echoes_r     <= echoes_nxt;
    end
  end

endmodule

FILE: rtl/framed_serial_link_xor_ack.sv
// ----------------------------------------------------------------------------
// framed_serial_link_xor_ack
// Half-duplex framed link engine with XOR checksum and ACK/NAK handshake.
// ----------------------------------------------------------------------------
// Output: the results of an accepted transaction are registered into the output queue.
// Throughput: a transaction causing n results (0 to 4) occupies the output
//   queue until its last result leaves; the next is taken as the last result
//   leaves, so 1 transaction per cycle at 0 or 1 results while out_stall is low.
// Reset: rst_n synchronous, active low; clears link state, output queue and
//   restores register defaults.
module framed_serial_link_xor_ack #(
  parameter int LENGTH_BITS = fslxa_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_line_byte,
  input  logic [3:0]  in_device,
  input  logic [15:0] in_frame_length,
  input  logic [7:0]  in_payload_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_data,
  output logic        out_done_res,
  output logic        out_success,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_rx_length,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fslxa_pkg::cfg_t                          cfg;
  fslxa_pkg::item_t                         item;
  fslxa_pkg::burst_t                        burst;
  fslxa_pkg::res_t [fslxa_pkg::BURST_MAX-1:0] q_r;
  logic [fslxa_pkg::BURST_CW-1:0]           cnt_r;
  logic                                     in_fire;
  logic                                     out_fire;

  fslxa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.mode         = in_mode;
  assign item.line_byte    = in_line_byte;
  assign item.device       = in_device;
  assign item.frame_length = in_frame_length;
  assign item.payload_byte = in_payload_byte;

  // Take a new transaction once the queue is empty or its last result leaves
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = (cnt_r > fslxa_pkg::BURST_CW'(1)) ||
                     ((cnt_r == fslxa_pkg::BURST_CW'(1)) && out_stall);
  assign in_fire   = in_valid && !in_stall;

  fslxa_engine #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .item   (item),
    .cfg    (cfg),
    .burst  (burst)
  );

  // Result queue: count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= burst.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - fslxa_pkg::BURST_CW'(1);
    end
  end

  // Result queue: payload, shifts toward slot 0
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r <= burst.slot;
    end else if (out_fire) begin
      for (int i = 0; i < fslxa_pkg::BURST_MAX - 1; i++) begin
        q_r[i] <= q_r[i+1];
      end
    end
  end

  assign out_tx_valid   = q_r[0].tx_valid;
  assign out_tx_byte    = q_r[0].tx_byte;
  assign out_rx_valid   = q_r[0].rx_valid;
  assign out_rx_data    = q_r[0].rx_data;
  assign out_done_res   = q_r[0].done_res;
  assign out_success    = q_r[0].success;
  assign out_error_code = q_r[0].error_code;
  assign out_rx_length  = q_r[0].rx_length;
  assign out_last       = q_r[0].last;

endmodule

FILE: rtl/fslxa_chk.sv
// ----------------------------------------------------------------------------
// fslxa_chk
// Port-level checks for the framed link engine, bound to the top level.
// ----------------------------------------------------------------------------
module fslxa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_byte,
  input logic        out_rx_valid,
  input logic        out_done_res,
  input logic        out_success,
  input logic [2:0]  out_error_code,
  input logic [15:0] out_rx_length,
  input logic        out_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_last))
    else $error("stalled result changed");

  // Empty output queue never blocks the input side
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with nothing to deliver");

  // A result cannot both transmit and deliver a payload byte
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tx_valid && out_rx_valid))
    else $error("tx and rx in one result");

  // Status fields only on a finished operation
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> (out_error_code == 3'd0) && (out_rx_length == 16'd0)
                                   && !out_success)
    else $error("status without done");

  // A reported length implies success
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rx_length != 16'd0) |-> out_success && (out_error_code == 3'd0))
    else $error("length on failed operation");

endmodule

bind framed_serial_link_xor_ack fslxa_chk u_fslxa_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_tx_valid   (out_tx_valid),
  .out_tx_byte    (out_tx_byte),
  .out_rx_valid   (out_rx_valid),
  .out_done_res   (out_done_res),
  .out_success    (out_success),
  .out_error_code (out_error_code),
  .out_rx_length  (out_rx_length),
  .out_last       (out_last)
);
